### rtl/core/aiob_pkg.sv
package aiob_pkg;

   localparam int DATA_BYTES = 64;
   localparam int COIN_SLOTS = 2;
   localparam int IDX_W      = $clog2(DATA_BYTES);
   localparam int SLOT_W     = (COIN_SLOTS > 1) ? $clog2(COIN_SLOTS) : 1;

   localparam logic [2:0] OP_LOAD    = 3'd0;
   localparam logic [2:0] OP_REQUEST = 3'd1;
   localparam logic [2:0] OP_SW_PRS  = 3'd2;
   localparam logic [2:0] OP_SW_REL  = 3'd3;
   localparam logic [2:0] OP_BT_PRS  = 3'd4;
   localparam logic [2:0] OP_BT_REL  = 3'd5;
   localparam logic [2:0] OP_COIN    = 3'd6;
   localparam logic [2:0] OP_NOP     = 3'd7;

   localparam logic [7:0] CMD_VERSION = 8'h0F;
   localparam logic [7:0] CMD_SWITCH  = 8'h10;
   localparam logic [7:0] CMD_BUTTON  = 8'h11;
   localparam logic [7:0] CMD_READER  = 8'h31;
   localparam logic [7:0] CMD_COIN    = 8'h41;
   localparam logic [7:0] CMD_ECHO0   = 8'h51;

   localparam logic [0:0] REG_ALT_MODE = 1'd0;
   localparam logic [0:0] REG_VERSION  = 1'd1;

   // Card reply length for a sub-command (0 for unknown).
   function automatic logic [4:0] card_len(input logic [7:0] sub);
      logic [4:0] n;
      begin
         n = 5'd0;
         unique case (sub)
            8'h78, 8'h7B:               n = 5'd6;
            8'h7A, 8'h9F, 8'hA7, 8'h80: n = 5'd4;
            8'hAC:                      n = 5'd12;
            8'hAF:                      n = 5'd20;
            default:                    n = 5'd0;
         endcase
         return n;
      end
   endfunction

   // Fixed card payload byte at position pos (7 and up), valid when pos < 4+n.
   function automatic logic [7:0] card_byte(input logic [7:0] sub, input logic [5:0] pos);
      logic [7:0] b;
      begin
         b = 8'h00;
         unique case (sub)
            8'h78:   b = (pos == 6'd9) ? 8'hFF : 8'h00;
            8'h80:   b = (pos == 6'd7) ? 8'h0D : 8'h00;
            8'hAC:   b = (pos >= 6'd12) ? 8'h55 : ((pos >= 6'd8) ? 8'hAA : 8'h00);
            8'hAF:   b = (pos == 6'd23) ? 8'h91 : ((pos >= 6'd8) ? 8'h88 : 8'h00);
            default: b = 8'h00;
         endcase
         return b;
      end
   endfunction

endpackage

### rtl/core/arcade_io_board_responder.sv
// Arcade I/O board responder. Event items (switch/button press and release,
// coin switch) and byte loads are taken whenever the block is idle. A
// request item streams DATA_BYTES response items, built one byte per cycle,
// while the output is not stalled, by a shared byte generator reading the
// request buffer memory. After a request is accepted the input stays not
// ready until the last byte is emitted: a first sweep over the buffer (one
// read per cycle on its single read port, read data registered in rd_ff)
// accumulates the packet sum and the IC-card parity; a second sweep emits the
// bytes, the last with the sum. Request bytes 0 and 5 (card channel and
// sub-command) are also kept in registers as they are loaded. Coin counters
// reported by the coin command are cleared when the request is accepted; the
// reply reads a snapshot taken at that edge.
module arcade_io_board_responder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[2:0]
   input  logic [2:0]  req_tuser,
   // byte_index[5:0], byte_value[13:6], command[21:14],
   // source_node[29:22], dest_node[37:30], bit_mask[53:38],
   // coin_slot[57:54], coin_pressed[58]
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_index[5:0], out_byte[13:6], packet_sum[21:14], reply_source[29:22],
   // reply_dest[37:30], reply_command[45:38]
   output logic [47:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import aiob_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SUM  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [2:0]  op;
   logic [5:0]  in_idx;
   logic [7:0]  in_val, in_cmd, in_src, in_dst;
   logic [15:0] in_mask;
   logic [3:0]  in_slot;
   logic        in_press;

   assign op       = req_tuser;
   assign in_idx   = req_tdata[5:0];
   assign in_val   = req_tdata[13:6];
   assign in_cmd   = req_tdata[21:14];
   assign in_src   = req_tdata[29:22];
   assign in_dst   = req_tdata[37:30];
   assign in_mask  = req_tdata[53:38];
   assign in_slot  = req_tdata[57:54];
   assign in_press = req_tdata[58];

   logic [7:0] mem [DATA_BYTES];
   logic [7:0] rd_ff, d0_ff, sub_ff;

   logic [1:0]        state_ff, state_in;
   logic [IDX_W:0]    cnt_ff, cnt_in;     // read address sweep
   logic              pend_ff, pend_in;   // rd_ff holds byte of pos_ff
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [7:0]  sum_ff, sum_in, par_ff, par_in;
   logic [7:0]  cmd_ff, src_ff, dst_ff;
   logic        alt_ff;
   logic [15:0] ver_ff, sw_ff, bt_ff;
   logic [15:0] coin_ff [COIN_SLOTS];
   logic [COIN_SLOTS-1:0] mark_ff;
   logic [15:0] snap_ff [COIN_SLOTS];     // counts frozen for the coin reply
   logic        ov_ff, ov_in;             // output register full
   logic [47:0] od_ff;
   logic        ol_ff;

   logic        acc;
   logic [7:0]  gen_byte, coin_byte;
   logic        coin_hit;
   logic [4:0]  nlen;

   assign req_tready = (state_ff == ST_IDLE);
   assign acc        = req_tvalid && req_tready;
   assign nlen       = card_len(sub_ff);

   // Coin record lookup: position -> slot among nonzero counts (narrow scan).
   always_comb begin
      logic [IDX_W:0] rec;
      coin_byte = 8'h00;
      coin_hit  = 1'b0;
      rec = '0;
      for (int i = 0; i < COIN_SLOTS; i++) begin
         if (snap_ff[i] != 16'd0) begin
            if ({1'b0, pos_ff} == rec) begin
               coin_hit = 1'b1; coin_byte = 8'h31 + 8'(i);
            end else if ({1'b0, pos_ff} == rec + 1'd1) begin
               coin_hit = 1'b1; coin_byte = 8'h00;
            end else if ({1'b0, pos_ff} == rec + 2'd2) begin
               coin_hit = 1'b1; coin_byte = snap_ff[i][7:0];
            end else if ({1'b0, pos_ff} == rec + 2'd3) begin
               coin_hit = 1'b1; coin_byte = snap_ff[i][15:8];
            end
            rec = rec + 3'd4;
         end
      end
      if (!coin_hit && {1'b0, pos_ff} == rec) begin
         coin_hit = 1'b1; coin_byte = 8'h00;
      end
   end

   aiob_byte_gen u_gen (
      .pos(pos_ff), .buf_byte(rd_ff), .cmd(cmd_ff), .d0(d0_ff), .sub(sub_ff),
      .par(par_ff), .coin_byte(coin_byte), .coin_hit(coin_hit), .alt_mode(alt_ff),
      .version(ver_ff), .switches(sw_ff), .buttons(bt_ff), .byte_out(gen_byte)
   );

   logic read_en, fire, out_free;
   assign out_free = !ov_ff || rsp_tready;
   // take a byte when the read data is present and, in the emit sweep, the output slot is free
   assign fire = pend_ff && (state_ff == ST_SUM || out_free);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      pend_in  = pend_ff;
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      par_in   = par_ff;
      ov_in    = ov_ff && !rsp_tready;
      read_en  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc && op == OP_REQUEST) begin
               state_in = ST_SUM;
               cnt_in = '0; pend_in = 1'b0; sum_in = '0; par_in = '0;
            end
         end
         ST_SUM, ST_EMIT: begin
            if (fire) begin
               pend_in = 1'b0;
               if (state_ff == ST_SUM) begin
                  sum_in = sum_ff + gen_byte;
                  if ({1'b0, pos_ff} >= 7'd5 && {1'b0, pos_ff} < 7'd4 + {2'b0, nlen})
                     par_in = par_ff ^ gen_byte;
               end else begin
                  ov_in = 1'b1;
               end
               if (pos_ff == IDX_W'(DATA_BYTES - 1)) begin
                  if (state_ff == ST_SUM) begin
                     state_in = ST_EMIT; cnt_in = '0;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
            if ((!pend_ff || fire) && cnt_ff < (IDX_W+1)'(DATA_BYTES)
                && !(fire && pos_ff == IDX_W'(DATA_BYTES - 1))) begin
               read_en = 1'b1;
               pend_in = 1'b1;
               pos_in  = cnt_ff[IDX_W-1:0];
               cnt_in  = cnt_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (acc && op == OP_LOAD && {1'b0, in_idx} < (IDX_W+1)'(DATA_BYTES))
         mem[in_idx[IDX_W-1:0]] <= in_val;
      if (read_en) rd_ff <= mem[cnt_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0; pend_ff <= 1'b0; ov_ff <= 1'b0;
         alt_ff <= 1'b0; ver_ff <= 16'd260;
         sw_ff <= 16'hFFFF; bt_ff <= '0; mark_ff <= '0;
         for (int i = 0; i < COIN_SLOTS; i++) coin_ff[i] <= '0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; pend_ff <= pend_in;
         ov_ff <= ov_in;
         if (csr_we) begin
            if (csr_index == REG_ALT_MODE) alt_ff <= csr_wdata[0];
            else ver_ff <= csr_wdata;
         end
         if (acc) begin
            unique case (op)
               OP_SW_PRS: sw_ff <= sw_ff & ~in_mask;
               OP_SW_REL: sw_ff <= sw_ff | in_mask;
               OP_BT_PRS: bt_ff <= bt_ff | in_mask;
               OP_BT_REL: bt_ff <= bt_ff & ~in_mask;
               OP_COIN: if (in_slot < 4'(COIN_SLOTS)) begin
                  if (in_press && !mark_ff[in_slot[SLOT_W-1:0]])
                     coin_ff[in_slot[SLOT_W-1:0]] <= coin_ff[in_slot[SLOT_W-1:0]] + 1'b1;
                  mark_ff[in_slot[SLOT_W-1:0]] <= in_press;
               end
               OP_REQUEST: if (in_cmd == CMD_COIN)
                  for (int i = 0; i < COIN_SLOTS; i++) coin_ff[i] <= '0;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in; sum_ff <= sum_in; par_ff <= par_in;
      if (acc && op == OP_REQUEST) begin
         cmd_ff <= in_cmd; src_ff <= in_src; dst_ff <= in_dst;
         for (int i = 0; i < COIN_SLOTS; i++)
            snap_ff[i] <= (in_cmd == CMD_COIN) ? coin_ff[i] : 16'd0;
      end
      // mirror request byte 0 (card channel) and byte 5 (sub-command) on load
      if (acc && op == OP_LOAD && in_idx == IDX_W'(0)) d0_ff <= in_val;
      if (acc && op == OP_LOAD && in_idx == IDX_W'(5)) sub_ff <= in_val;
      if (state_ff == ST_EMIT && fire) begin
         ol_ff <= (pos_ff == IDX_W'(DATA_BYTES - 1));
         od_ff <= {2'b0, cmd_ff, src_ff, dst_ff,
                   (pos_ff == IDX_W'(DATA_BYTES - 1)) ? sum_ff : 8'h00,
                   gen_byte, pos_ff};
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tlast  = ol_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !ov_ff || state_ff == ST_IDLE)
      else $error("ready outside idle");
   a_last_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[IDX_W-1:0] == IDX_W'(DATA_BYTES - 1))))
      else $error("last flag not on final byte");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("output changed while stalled");

endmodule

### rtl/core/aiob_byte_gen.sv
// Combinational response byte for one position, given the request snapshot.
module aiob_byte_gen (
   input  logic [aiob_pkg::IDX_W-1:0] pos,
   input  logic [7:0]                 buf_byte,
   input  logic [7:0]                 cmd,
   input  logic [7:0]                 d0,
   input  logic [7:0]                 sub,
   input  logic [7:0]                 par,
   input  logic [7:0]                 coin_byte,
   input  logic                       coin_hit,
   input  logic                       alt_mode,
   input  logic [15:0]                version,
   input  logic [15:0]                switches,
   input  logic [15:0]                buttons,
   output logic [7:0]                 byte_out
);
   import aiob_pkg::*;

   logic [4:0] n;
   logic [6:0] p;

   assign n = card_len(sub);
   assign p = {1'b0, pos};

   always_comb begin
      byte_out = buf_byte;
      unique case (cmd)
         CMD_VERSION: begin
            if (p == 7'd0 || p == 7'd1) byte_out = 8'h00;
            else if (p == 7'd2) byte_out = version[15:8];
            else if (p == 7'd3) byte_out = version[7:0];
         end
         CMD_SWITCH: begin
            if (!alt_mode && p == 7'd0) byte_out = switches[7:0];
            else if (!alt_mode && p == 7'd1) byte_out = switches[15:8];
         end
         CMD_BUTTON: begin
            if (p == 7'd50) byte_out = 8'h20;
            else if (p == 7'd54) byte_out = buttons[7:0];
            else if (p == 7'd55) byte_out = buttons[15:8];
         end
         CMD_READER: begin
            if (d0 == 8'h00) begin
               unique case (p)
                  7'd0:                      byte_out = 8'h00;
                  7'd1:                      byte_out = 8'h06;
                  7'd4, 7'd5, 7'd7:          byte_out = 8'h02;
                  7'd6:                      byte_out = 8'h80;
                  7'd8, 7'd9:                byte_out = 8'h03;
                  default:                   byte_out = buf_byte;
               endcase
            end else if (d0 == 8'h02) begin
               if (p == 7'd4 + {2'b0, n}) byte_out = par;
               else if (p == 7'd0) byte_out = 8'h02;
               else if (p == 7'd1) byte_out = {3'b0, n} + 8'd1;
               else if (p == 7'd4) byte_out = 8'h02;
               else if (p == 7'd5) byte_out = sub;
               else if (p == 7'd6) byte_out = {3'b0, n} - 8'd4;
               else if (p >= 7'd7 && p < 7'd4 + {2'b0, n})
                  byte_out = card_byte(sub, pos);
            end
         end
         CMD_COIN:  if (coin_hit) byte_out = coin_byte;
         CMD_ECHO0: if (p == 7'd0) byte_out = 8'h00;
         default:   byte_out = buf_byte;
      endcase
   end

endmodule

### bench/arcade_io_board_responder_tb.sv
module arcade_io_board_responder_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import aiob_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LAT         = 2 * DATA_BYTES + 8;

   typedef struct packed {
      logic [5:0] idx;
      logic [7:0] data;
      logic       last;
      logic [7:0] sum;
      logic [7:0] src;
      logic [7:0] dst;
      logic [7:0] cmd;
   } rsp_item_type;

   typedef struct {
      logic [2:0]  op;
      logic [5:0]  bidx;
      logic [7:0]  bval;
      logic [7:0]  cmd;
      logic [7:0]  src;
      logic [7:0]  dst;
      logic [15:0] mask;
      logic [3:0]  slot;
      logic        pressed;
   } req_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser = '0;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   arcade_io_board_responder u_top (.*);

   always #5 clock = ~clock;

   // Board image kept by the bench
   logic [7:0]  buf_img [DATA_BYTES];
   logic [15:0] sw_img, btn_img;
   logic [15:0] coins [COIN_SLOTS];
   logic [COIN_SLOTS-1:0] coin_marks;
   logic        alt_mode;
   logic [15:0] fw_ver;

   rsp_item_type pending_bytes[$];
   int          errors = 0;
   int          cycles = 0;

   // Typed-in checks for the directed table: index into the response, value
   int          fixed_pos[$];
   logic [7:0]  fixed_val[$];

   logic [7:0] resp_img [DATA_BYTES];

   function automatic void patch(int p, logic [7:0] v);
      if (p < DATA_BYTES) resp_img[p] = v;
   endfunction

   task automatic build_card();
      logic [7:0] sub;
      logic [7:0] par;
      int n;
      sub = buf_img[5];
      n = 0;
      par = 8'h00;
      patch(4, 8'h02);
      patch(5, sub);
      case (sub)
         8'h78: begin n = 6; patch(7, 8'h00); patch(8, 8'h00); patch(9, 8'hFF); end
         8'h7A, 8'h9F, 8'hA7: begin n = 4; patch(7, 8'h00); end
         8'h7B: begin n = 6; patch(7, 8'h00); patch(8, 8'h00); patch(9, 8'h00); end
         8'h80: begin n = 4; patch(7, 8'h0D); end
         8'hAC: begin
            n = 12; patch(7, 8'h00);
            for (int i = 0; i < 4; i++) begin
               patch(8 + i, 8'hAA);
               patch(12 + i, 8'h55);
            end
         end
         8'hAF: begin
            n = 20; patch(7, 8'h00);
            for (int i = 0; i < 15; i++) patch(8 + i, 8'h88);
            patch(23, 8'(12'h889 - 15 * 8'h88));
         end
         default: ;
      endcase
      patch(0, 8'h02);
      patch(1, 8'(n + 1));
      patch(6, 8'(n + 1 - 5));
      for (int i = 1; i < n; i++) par ^= resp_img[4 + i];
      patch(4 + n, par);
   endtask

   // Apply one accepted item to the image and queue the bytes it answers with
   task automatic predict_item(req_item_type it);
      int rec;
      logic [7:0] sum;
      rsp_item_type r;
      case (it.op)
         OP_LOAD:   buf_img[it.bidx] = it.bval;
         OP_SW_PRS: sw_img &= ~it.mask;
         OP_SW_REL: sw_img |= it.mask;
         OP_BT_PRS: btn_img |= it.mask;
         OP_BT_REL: btn_img &= ~it.mask;
         OP_COIN: if (it.slot < COIN_SLOTS) begin
            if (it.pressed && !coin_marks[it.slot]) coins[it.slot]++;
            coin_marks[it.slot] = it.pressed;
         end
         OP_REQUEST: begin
            for (int i = 0; i < DATA_BYTES; i++) resp_img[i] = buf_img[i];
            case (it.cmd)
               CMD_VERSION: begin
                  patch(0, 8'h00); patch(1, 8'h00);
                  patch(2, fw_ver[15:8]); patch(3, fw_ver[7:0]);
               end
               CMD_SWITCH: if (!alt_mode) begin
                  patch(0, sw_img[7:0]); patch(1, sw_img[15:8]);
               end
               CMD_BUTTON: begin
                  patch(50, 8'h20); patch(54, btn_img[7:0]); patch(55, btn_img[15:8]);
               end
               CMD_READER: begin
                  if (buf_img[0] == 8'h00) begin
                     patch(0, 8'h00); patch(1, 8'h06); patch(4, 8'h02); patch(5, 8'h02);
                     patch(6, 8'h80); patch(7, 8'h02); patch(8, 8'h03); patch(9, 8'h03);
                  end else if (buf_img[0] == 8'h02) begin
                     build_card();
                  end
               end
               CMD_COIN: begin
                  rec = 0;
                  for (int s = 0; s < COIN_SLOTS; s++) begin
                     if (coins[s] != 0) begin
                        patch(rec, 8'(8'h31 + s)); patch(rec + 1, 8'h00);
                        patch(rec + 2, coins[s][7:0]); patch(rec + 3, coins[s][15:8]);
                        coins[s] = 0;
                        rec += 4;
                     end
                  end
                  patch(rec, 8'h00);
               end
               CMD_ECHO0: patch(0, 8'h00);
               default: ;
            endcase
            sum = 8'h00;
            for (int i = 0; i < DATA_BYTES; i++) sum += resp_img[i];
            for (int i = 0; i < DATA_BYTES; i++) begin
               r.idx  = 6'(i);
               r.data = resp_img[i];
               r.last = (i == DATA_BYTES - 1);
               r.sum  = r.last ? sum : 8'h00;
               r.src  = it.dst;
               r.dst  = it.src;
               r.cmd  = it.cmd;
               pending_bytes.push_back(r);
            end
         end
         default: ;
      endcase
   endtask

   function automatic logic [63:0] pack_item(req_item_type it);
      return {5'b00000, it.pressed, it.slot, it.mask, it.dst, it.src, it.cmd,
              it.bval, it.bidx};
   endfunction

   // Result checker: compare every accepted byte with the oldest expectation
   always @(posedge clock) begin
      rsp_item_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.idx  = rsp_tdata[5:0];
         got.data = rsp_tdata[13:6];
         got.last = rsp_tlast;
         got.sum  = rsp_tdata[21:14];
         got.src  = rsp_tdata[29:22];
         got.dst  = rsp_tdata[37:30];
         got.cmd  = rsp_tdata[45:38];
         if (pending_bytes.size() == 0) begin
            $display("%0t: unexpected item %h", $time, got);
            errors++;
         end else begin
            want = pending_bytes.pop_front();
            if (got !== want) begin
               $display("%0t: expected %h, actual %h", $time, want, got);
               errors++;
            end
            // directed rows carry hand-typed byte values too
            if (fixed_pos.size() != 0 && fixed_pos[0] == int'(got.idx)) begin
               if (got.data !== fixed_val[0]) begin
                  $display("%0t: byte %0d expected %h, actual %h",
                           $time, got.idx, fixed_val[0], got.data);
                  errors++;
               end
               void'(fixed_pos.pop_front());
               void'(fixed_val.pop_front());
            end
         end
      end
   end

   // Receiver stall: draw a random wait for every item, with calm stretches
   initial begin
      int w;
      @(negedge clock);
      forever begin
         w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         if (w != 0) begin
            rsp_tready <= 1'b0;
            repeat (w) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Timeout guard
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send(req_item_type it, bit gaps);
      int w;
      w = gaps ? $urandom_range(0, 9) : 0;
      if (w != 0) begin
         req_tvalid <= 1'b0;
         repeat (w) @(negedge clock);
      end
      req_tuser  <= it.op;
      req_tdata  <= pack_item(it);
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_item(it);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_bytes.size() != 0) @(negedge clock);
      repeat (LAT) @(negedge clock);
   endtask

   task automatic write_reg(logic [0:0] r, logic [15:0] v);
      csr_we    <= 1'b1;
      csr_index <= r;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      if (r == REG_ALT_MODE) alt_mode = v[0];
      else fw_ver = v;
      @(negedge clock);
   endtask

   function automatic req_item_type mk(logic [2:0] op, logic [7:0] a = '0,
                                       logic [7:0] b = '0, logic [15:0] m = '0);
      req_item_type it;
      it.op = op; it.bidx = a[5:0]; it.bval = b; it.cmd = a;
      it.src = b; it.dst = ~b; it.mask = m; it.slot = a[3:0];
      it.pressed = b[0];
      return it;
   endfunction

   task automatic load_all(bit zero);
      for (int i = 0; i < DATA_BYTES; i++)
         send(mk(OP_LOAD, 8'(i), zero ? 8'h00 : 8'($urandom)), 1'b0);
   endtask

   function automatic req_item_type rand_item();
      req_item_type it;
      logic [63:0] d;
      d = {$urandom, $urandom};
      it.op = d[2:0]; it.bidx = d[8:3]; it.bval = d[16:9]; it.cmd = d[24:17];
      it.src = d[32:25]; it.dst = d[40:33]; it.mask = d[56:41];
      it.slot = d[60:57]; it.pressed = d[61];
      if (it.slot > 4'd3 && d[63]) it.slot = {3'b000, d[62]};
      return it;
   endfunction

   // Directed table: opcode, arg (command / index / slot), value, mask
   typedef struct {
      logic [2:0]  op;
      logic [7:0]  a;
      logic [7:0]  b;
      logic [15:0] m;
   } row_type;
   row_type dir_rows [20] = '{
      '{OP_REQUEST, CMD_SWITCH,  8'h00, 16'h0},     // switches all high after reset
      '{OP_REQUEST, CMD_VERSION, 8'hFF, 16'h0},     // reset version 0x0104
      '{OP_SW_PRS,  8'h00,       8'h00, 16'hFFFF},
      '{OP_REQUEST, CMD_SWITCH,  8'h12, 16'h0},     // all switches closed
      '{OP_SW_REL,  8'h00,       8'h00, 16'h00F0},
      '{OP_BT_PRS,  8'h00,       8'h00, 16'hFFFF},
      '{OP_BT_REL,  8'h00,       8'h00, 16'h0F0F},
      '{OP_REQUEST, CMD_BUTTON,  8'h34, 16'h0},
      '{OP_COIN,    8'h00,       8'h01, 16'h0},
      '{OP_COIN,    8'h00,       8'h01, 16'h0},     // held: no second count
      '{OP_COIN,    8'h00,       8'h00, 16'h0},
      '{OP_COIN,    8'h00,       8'h01, 16'h0},
      '{OP_COIN,    8'h01,       8'h01, 16'h0},
      '{OP_COIN,    8'h0F,       8'h01, 16'h0},     // slot out of range
      '{OP_REQUEST, CMD_COIN,    8'h56, 16'h0},
      '{OP_REQUEST, CMD_COIN,    8'h57, 16'h0},     // counters cleared
      '{OP_REQUEST, CMD_ECHO0,   8'h78, 16'h0},
      '{OP_REQUEST, CMD_READER,  8'h9A, 16'h0},     // barcode reader channel
      '{OP_REQUEST, 8'hFF,       8'hBC, 16'h0},     // unknown command
      '{OP_NOP,     8'h00,       8'h00, 16'h0}      // opcode seven, ignored
   };

   logic [7:0] card_subs [9] = '{8'h78, 8'h7A, 8'h9F, 8'hA7, 8'h7B, 8'h80, 8'hAC,
                                 8'hAF, 8'h33};

   initial begin
      req_item_type it;
      for (int i = 0; i < DATA_BYTES; i++) buf_img[i] = 8'h00;
      sw_img = 16'hFFFF; btn_img = 16'h0; coin_marks = '0;
      for (int s = 0; s < COIN_SLOTS; s++) coins[s] = 16'h0;
      alt_mode = 1'b0; fw_ver = 16'd260;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Fill the whole buffer before any request
      load_all(1'b1);

      foreach (dir_rows[k]) begin
         // rows with typed-in values start on an empty pipe so they match up
         if (dir_rows[k].op == OP_REQUEST &&
             (dir_rows[k].a == CMD_VERSION ||
              (dir_rows[k].a == CMD_SWITCH &&
               (dir_rows[k].b == 8'h00 || dir_rows[k].b == 8'h12))))
            drain();
         if (dir_rows[k].op == OP_REQUEST && dir_rows[k].a == CMD_SWITCH &&
             dir_rows[k].b == 8'h00) begin
            fixed_pos.push_back(0); fixed_val.push_back(8'hFF);
            fixed_pos.push_back(1); fixed_val.push_back(8'hFF);
         end
         if (dir_rows[k].op == OP_REQUEST && dir_rows[k].a == CMD_VERSION) begin
            fixed_pos.push_back(2); fixed_val.push_back(8'h01);
            fixed_pos.push_back(3); fixed_val.push_back(8'h04);
         end
         if (dir_rows[k].op == OP_REQUEST && dir_rows[k].a == CMD_SWITCH &&
             dir_rows[k].b == 8'h12) begin
            fixed_pos.push_back(0); fixed_val.push_back(8'h00);
         end
         send(mk(dir_rows[k].op, dir_rows[k].a, dir_rows[k].b, dir_rows[k].m), 1'b1);
      end

      // IC card channel: every sub-command and an unknown one
      send(mk(OP_LOAD, 8'd0, 8'h02), 1'b0);
      foreach (card_subs[k]) begin
         send(mk(OP_LOAD, 8'd5, card_subs[k]), 1'b0);
         send(mk(OP_REQUEST, CMD_READER, 8'(k)), 1'b1);
      end
      send(mk(OP_LOAD, 8'd0, 8'h07), 1'b0);         // other channel: echo
      send(mk(OP_REQUEST, CMD_READER, 8'h11), 1'b1);

      // Configuration extremes; hold off until the block is idle
      drain();
      write_reg(REG_ALT_MODE, 16'h0001);
      write_reg(REG_VERSION, 16'hFFFF);
      send(mk(OP_REQUEST, CMD_SWITCH, 8'h21), 1'b1);
      send(mk(OP_REQUEST, CMD_VERSION, 8'h22), 1'b1);
      drain();
      write_reg(REG_VERSION, 16'h0000);
      send(mk(OP_REQUEST, CMD_VERSION, 8'h23), 1'b1);

      // Random part: random loads, events and requests over the filled buffer
      for (int phase = 0; phase < 2; phase++) begin
         drain();
         write_reg(REG_ALT_MODE, 16'($urandom_range(0, 1)));
         write_reg(REG_VERSION, 16'($urandom));
         if ($urandom_range(0, 1)) begin
            send(mk(OP_LOAD, 8'd0, 8'h02), 1'b0);
            send(mk(OP_LOAD, 8'd5, card_subs[$urandom_range(0, 8)]), 1'b0);
         end
         for (int k = 0; k < 30; k++) begin
            it = rand_item();
            if ($urandom_range(0, 3) == 0) begin
               it.op = OP_REQUEST;
               case ($urandom_range(0, 6))
                  0: it.cmd = CMD_VERSION;
                  1: it.cmd = CMD_SWITCH;
                  2: it.cmd = CMD_BUTTON;
                  3: it.cmd = CMD_READER;
                  4: it.cmd = CMD_COIN;
                  5: it.cmd = CMD_ECHO0;
                  default: ;
               endcase
            end else if (it.op == OP_REQUEST && $urandom_range(0, 1)) begin
               it.op = OP_COIN;
            end
            // halfway through each phase, wait for the block to drain before the next item
            if (k == 15) drain();
            send(it, $urandom_range(0, 2) != 0);
         end
      end

      drain();
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### arcade_io_board_responder.f
rtl/core/aiob_pkg.sv
rtl/core/aiob_byte_gen.sv
rtl/core/arcade_io_board_responder.sv
bench/arcade_io_board_responder_tb.sv
